// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising clk edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/gpl_pkg.sv -----
// Types and constants of the GPIO port with configuration lock.
package gpl_pkg;

    localparam int PINS      = 16;
    localparam int WORD_W    = 32;
    localparam int SEL_W     = 3;
    localparam int KEY_POS   = 16;
    localparam int NIB_PINS  = 8;

    localparam logic [WORD_W-1:0] CFG_RESET = 32'h4444_4444;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [SEL_W-1:0] SEL_CFG_LO = 3'd0;
    localparam logic [SEL_W-1:0] SEL_CFG_HI = 3'd1;
    localparam logic [SEL_W-1:0] SEL_IDR    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_ODR    = 3'd3;
    localparam logic [SEL_W-1:0] SEL_BSRR   = 3'd4;
    localparam logic [SEL_W-1:0] SEL_BRR    = 3'd5;
    localparam logic [SEL_W-1:0] SEL_LCKR   = 3'd6;

    typedef struct packed {
        logic              req_type;
        logic [SEL_W-1:0]  reg_select;
        logic [WORD_W-1:0] write_data;
        logic [PINS-1:0]   pin_levels;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [PINS-1:0]   pin_drive;
        logic              lock_active;
    } rsp_t;

    typedef struct packed {
        logic lock_key;
    } status_t;

endpackage

// ----- src/gpl_req_if.sv -----
// Request channel: one register access per transfer.
interface gpl_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [gpl_pkg::SEL_W-1:0]       reg_select;
    logic [gpl_pkg::WORD_W-1:0]      write_data;
    logic [gpl_pkg::PINS-1:0]        pin_levels;

    modport source (output valid, output req_type, output reg_select, output write_data,
                    output pin_levels, input ready);
    modport sink   (input valid, input req_type, input reg_select, input write_data,
                    input pin_levels, output ready);
endinterface

// ----- src/gpl_rsp_if.sv -----
// Response channel: one result per access.
interface gpl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [gpl_pkg::WORD_W-1:0]      read_data;
    logic [gpl_pkg::PINS-1:0]        pin_drive;
    logic                            lock_active;

    modport source (output valid, output read_data, output pin_drive, output lock_active,
                    input ready);
    modport sink   (input valid, input read_data, input pin_drive, input lock_active,
                    output ready);
endinterface

// ----- src/gpl_regs.sv -----
// Port registers, lock key sequence and access decode.
module gpl_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  gpl_pkg::req_t     req,
    output gpl_pkg::rsp_t     rsp,
    output gpl_pkg::status_t  status
);

    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_ONE   = 2'd1;
    localparam logic [1:0] STEP_ZERO  = 2'd2;
    localparam logic [1:0] STEP_ARMED = 2'd3;

    logic [gpl_pkg::WORD_W-1:0] cfg_lo_reg, cfg_lo_next;
    logic [gpl_pkg::WORD_W-1:0] cfg_hi_reg, cfg_hi_next;
    logic [gpl_pkg::PINS-1:0]   odr_reg, odr_next;
    logic [gpl_pkg::PINS-1:0]   lck_bits_reg, lck_bits_next;
    logic                       lck_key_reg, lck_key_next;
    logic [1:0]                 step_reg, step_next;
    logic [gpl_pkg::WORD_W-1:0] keep_lo, keep_hi;
    logic [gpl_pkg::WORD_W-1:0] rd;
    logic [gpl_pkg::PINS-1:0]   wr_bits;
    logic                       wr_key;
    logic                       same_bits;

    always_comb
    begin
        for (int i = 0; i < gpl_pkg::NIB_PINS; i++)
        begin
            keep_lo[4*i +: 4] = {4{lck_key_reg & lck_bits_reg[i]}};
            keep_hi[4*i +: 4] = {4{lck_key_reg & lck_bits_reg[gpl_pkg::NIB_PINS + i]}};
        end
    end

    assign wr_bits   = req.write_data[gpl_pkg::PINS-1:0];
    assign wr_key    = req.write_data[gpl_pkg::KEY_POS];
    assign same_bits = (wr_bits == lck_bits_reg);

    always_comb
    begin
        cfg_lo_next   = cfg_lo_reg;
        cfg_hi_next   = cfg_hi_reg;
        odr_next      = odr_reg;
        lck_bits_next = lck_bits_reg;
        lck_key_next  = lck_key_reg;
        step_next     = step_reg;
        rd            = '0;
        if (req.req_type == gpl_pkg::REQ_WRITE)
        begin
            unique case (req.reg_select)
                gpl_pkg::SEL_CFG_LO:
                    cfg_lo_next = (cfg_lo_reg & keep_lo) | (req.write_data & ~keep_lo);
                gpl_pkg::SEL_CFG_HI:
                    cfg_hi_next = (cfg_hi_reg & keep_hi) | (req.write_data & ~keep_hi);
                gpl_pkg::SEL_ODR:
                    odr_next = wr_bits;
                gpl_pkg::SEL_BSRR:
                    odr_next = (odr_reg & ~req.write_data[gpl_pkg::WORD_W-1:gpl_pkg::PINS])
                               | wr_bits;
                gpl_pkg::SEL_BRR:
                    odr_next = odr_reg & ~wr_bits;
                gpl_pkg::SEL_LCKR:
                begin
                    if (!lck_key_reg)
                    begin
                        lck_bits_next = wr_bits;
                        priority if (step_reg == STEP_ONE && !wr_key && same_bits)
                            step_next = STEP_ZERO;
                        else if (step_reg == STEP_ZERO && wr_key && same_bits)
                            step_next = STEP_ARMED;
                        else
                            step_next = wr_key ? STEP_ONE : STEP_IDLE;
                    end
                end
                default:
                    ;
            endcase
        end
        else
        begin
            unique case (req.reg_select)
                gpl_pkg::SEL_CFG_LO:
                    rd = cfg_lo_reg;
                gpl_pkg::SEL_CFG_HI:
                    rd = cfg_hi_reg;
                gpl_pkg::SEL_IDR:
                    rd = {{(gpl_pkg::WORD_W-gpl_pkg::PINS){1'b0}}, req.pin_levels};
                gpl_pkg::SEL_ODR:
                    rd = {{(gpl_pkg::WORD_W-gpl_pkg::PINS){1'b0}}, odr_reg};
                gpl_pkg::SEL_LCKR:
                begin
                    rd = {{(gpl_pkg::WORD_W-gpl_pkg::PINS-1){1'b0}}, lck_key_reg,
                          lck_bits_reg};
                    if (!lck_key_reg && step_reg == STEP_ARMED)
                    begin
                        lck_key_next = 1'b1;
                        step_next    = STEP_IDLE;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_lo_reg   <= gpl_pkg::CFG_RESET;
            cfg_hi_reg   <= gpl_pkg::CFG_RESET;
            odr_reg      <= '0;
            lck_bits_reg <= '0;
            lck_key_reg  <= 1'b0;
            step_reg     <= STEP_IDLE;
        end
        else if (en)
        begin
            cfg_lo_reg   <= cfg_lo_next;
            cfg_hi_reg   <= cfg_hi_next;
            odr_reg      <= odr_next;
            lck_bits_reg <= lck_bits_next;
            lck_key_reg  <= lck_key_next;
            step_reg     <= step_next;
        end
    end

    assign rsp.read_data   = rd;
    assign rsp.pin_drive   = odr_next;
    assign rsp.lock_active = lck_key_next;
    assign status.lock_key = lck_key_reg;

endmodule

// ----- src/gpio_port_with_config_lock_unit.sv -----
// Top level of the GPIO port with configuration lock.
//
//   channel | dir | transfer
//   --------+-----+-------------------------------------------------------
//   req     | in  | one read or write access to one port register
//   rsp     | out | read data, pin drive and lock state after that access
//
// An access passes through the request register and then the
// response register; one access per cycle is sustained while rsp is ready.
// All decode and register update sit between those two registers.
// Reset returns the port registers to their reset values and clears both stage valids.
// A stall on rsp holds both stages; req is ready while the request stage is empty or the pipeline advances.
`include "assert_macros.svh"

module gpio_port_with_config_lock_unit (
    input  logic     clk,
    input  logic     rst_n,
    gpl_req_if.sink  req,
    gpl_rsp_if.source rsp
);

    logic              req_vld_reg, req_vld_next;
    gpl_pkg::req_t     req_reg, req_next;
    logic              rsp_vld_reg, rsp_vld_next;
    gpl_pkg::rsp_t     rsp_reg, rsp_next;
    gpl_pkg::rsp_t     result;
    gpl_pkg::status_t  status;
    logic              advance;
    logic              req_take;
    logic              en;

    assign advance  = !rsp_vld_reg || rsp.ready;
    assign en       = req_vld_reg && advance;
    assign req.ready = !req_vld_reg || advance;
    assign req_take = req.valid && req.ready;

    always_comb
    begin
        req_vld_next = req_vld_reg;
        req_next     = req_reg;
        rsp_vld_next = rsp_vld_reg;
        rsp_next     = rsp_reg;
        if (advance)
        begin
            rsp_vld_next = req_vld_reg;
            rsp_next     = result;
        end
        if (req.ready)
        begin
            req_vld_next = req.valid;
            req_next     = '{req_type:   req.req_type,
                             reg_select: req.reg_select,
                             write_data: req.write_data,
                             pin_levels: req.pin_levels};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    gpl_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .req    (req_reg),
        .rsp    (result),
        .status (status)
    );

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.read_data   = rsp_reg.read_data;
    assign rsp.pin_drive   = rsp_reg.pin_drive;
    assign rsp.lock_active = rsp_reg.lock_active;

    `ASSERT_CLK(a_lock_sticky, status.lock_key |=> status.lock_key, "lock dropped before reset")
    `ASSERT_CLK(a_rsp_from_req, $rose(rsp_vld_reg) |-> $past(req_vld_reg), "response without request")
    `ASSERT_CLK(a_write_reads_zero, (en && req_reg.req_type == gpl_pkg::REQ_WRITE) |=> (rsp_reg.read_data == '0), "write returned read data")
    `ASSERT_ALWAYS(a_take_needs_room, req_take |-> (!req_vld_reg || advance), "request taken over a held one")

endmodule

// ----- tb/gpio_port_with_config_lock_unit_tb.sv -----
// Self-checking testbench for the GPIO port with configuration lock.
`timescale 1ns / 1ps

module gpio_port_with_config_lock_unit_tb;

    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_GOT_ONE,
        KEY_GOT_ZERO,
        KEY_ARMED
    } key_step_t;

    localparam int RANDOM_ACCESSES = 1580;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_CYCLES    = 10;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [gpl_pkg::SEL_W-1:0] SEL_UNUSED = 3'd7;

    class port_checker_t;
        gpl_pkg::rsp_t expected_rsp[$];
        logic [31:0]   cfg_lo;
        logic [31:0]   cfg_hi;
        logic [15:0]   out_latch;
        logic [15:0]   lock_mask;
        logic          key_set;
        key_step_t     key_step;
        int            mismatches;
        int            results_seen;
        int            reads;
        int            writes;
        int            lock_at;

        function new();
            cfg_lo       = gpl_pkg::CFG_RESET;
            cfg_hi       = gpl_pkg::CFG_RESET;
            out_latch    = '0;
            lock_mask    = '0;
            key_set      = 1'b0;
            key_step     = KEY_IDLE;
            mismatches   = 0;
            results_seen = 0;
            reads        = 0;
            writes       = 0;
            lock_at      = 0;
        endfunction

        function logic [31:0] frozen_merge(logic [31:0] old_w, logic [31:0] new_w, int base);
            logic [31:0] keep;
            keep = '0;
            if (key_set)
            begin
                for (int i = 0; i < gpl_pkg::NIB_PINS; i++)
                begin
                    if (lock_mask[base + i])
                        keep[4*i +: 4] = 4'hf;
                end
            end
            return (old_w & keep) | (new_w & ~keep);
        endfunction

        function void note_access(gpl_pkg::req_t a);
            logic [31:0]   rd;
            logic [15:0]   bits;
            logic          key_bit;
            gpl_pkg::rsp_t r;
            rd      = '0;
            bits    = a.write_data[15:0];
            key_bit = a.write_data[gpl_pkg::KEY_POS];
            if (a.req_type == gpl_pkg::REQ_WRITE)
            begin
                writes++;
                case (a.reg_select)
                    gpl_pkg::SEL_CFG_LO: cfg_lo = frozen_merge(cfg_lo, a.write_data, 0);
                    gpl_pkg::SEL_CFG_HI:
                        cfg_hi = frozen_merge(cfg_hi, a.write_data, gpl_pkg::NIB_PINS);
                    gpl_pkg::SEL_ODR:    out_latch = bits;
                    gpl_pkg::SEL_BSRR:   out_latch = (out_latch & ~a.write_data[31:16]) | bits;
                    gpl_pkg::SEL_BRR:    out_latch = out_latch & ~bits;
                    gpl_pkg::SEL_LCKR:
                    begin
                        if (!key_set)
                        begin
                            if (key_step == KEY_GOT_ONE && !key_bit && bits == lock_mask)
                                key_step = KEY_GOT_ZERO;
                            else if (key_step == KEY_GOT_ZERO && key_bit && bits == lock_mask)
                                key_step = KEY_ARMED;
                            else if (key_bit)
                                key_step = KEY_GOT_ONE;
                            else
                                key_step = KEY_IDLE;
                            lock_mask = bits;
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                reads++;
                case (a.reg_select)
                    gpl_pkg::SEL_CFG_LO: rd = cfg_lo;
                    gpl_pkg::SEL_CFG_HI: rd = cfg_hi;
                    gpl_pkg::SEL_IDR:    rd = {16'h0, a.pin_levels};
                    gpl_pkg::SEL_ODR:    rd = {16'h0, out_latch};
                    gpl_pkg::SEL_LCKR:
                    begin
                        rd = {15'h0, key_set, lock_mask};
                        if (!key_set && key_step == KEY_ARMED)
                        begin
                            key_set  = 1'b1;
                            key_step = KEY_IDLE;
                            lock_at  = reads + writes;
                        end
                    end
                    default: ;
                endcase
            end
            r.read_data   = rd;
            r.pin_drive   = out_latch;
            r.lock_active = key_set;
            expected_rsp.push_back(r);
        endfunction

        function void check_response(gpl_pkg::rsp_t got);
            gpl_pkg::rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: read_data %h pin_drive %h lock_active %b",
                             got.read_data, got.pin_drive, got.lock_active);
                return;
            end
            want = expected_rsp.pop_front();
            results_seen++;
            if (got.read_data !== want.read_data || got.pin_drive !== want.pin_drive ||
                got.lock_active !== want.lock_active)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("response %0d exp %h %h %b got %h %h %b",
                             results_seen, want.read_data, want.pin_drive,
                             want.lock_active, got.read_data, got.pin_drive,
                             got.lock_active);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    int            src_idle_pct;
    int            sink_idle_pct;
    logic          hold_rsp;
    logic          start_hold;
    port_checker_t sb = new();

    gpl_req_if req_ch();
    gpl_rsp_if rsp_ch();

    gpio_port_with_config_lock_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_response(gpl_pkg::rsp_t'({rsp_ch.read_data, rsp_ch.pin_drive,
                                                   rsp_ch.lock_active}));
            rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        hold_rsp = 1'b0;
        wait (start_hold);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    function automatic gpl_pkg::req_t make_access(logic kind,
                                                  logic [gpl_pkg::SEL_W-1:0] sel,
                                                  logic [gpl_pkg::WORD_W-1:0] data,
                                                  logic [gpl_pkg::PINS-1:0] pins);
        gpl_pkg::req_t a;
        a.req_type   = kind;
        a.reg_select = sel;
        a.write_data = data;
        a.pin_levels = pins;
        return a;
    endfunction

    task automatic send_access(input gpl_pkg::req_t a);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= a.req_type;
        req_ch.reg_select <= a.reg_select;
        req_ch.write_data <= a.write_data;
        req_ch.pin_levels <= a.pin_levels;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_access(a);
    endtask

    initial
    begin
        gpl_pkg::req_t a;
        int            key_pos;
        int            unlock_at;
        logic [15:0]   seq_bits;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = gpl_pkg::REQ_READ;
        req_ch.reg_select = gpl_pkg::SEL_CFG_LO;
        req_ch.write_data = '0;
        req_ch.pin_levels = '0;
        src_idle_pct      = 21;
        sink_idle_pct     = 71;
        start_hold        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_CFG_LO, 32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_CFG_HI, 32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_IDR,    32'hffff_ffff, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_IDR,    32'h0,         16'hffff));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_IDR,    32'hffff_ffff, 16'hffff));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_ODR,    32'hffff_ffff, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_ODR,    32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_BRR,    32'hffff_00ff, 16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_BSRR,   32'hffff_0000, 16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_BSRR,   32'hffff_ffff, 16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_BSRR,   32'h5555_0000, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_BSRR,   32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_BRR,    32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, SEL_UNUSED,          32'hffff_ffff, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  SEL_UNUSED,          32'h0,         16'hffff));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_CFG_LO, 32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_CFG_HI, 32'hffff_ffff, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_CFG_LO, 32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_LCKR,   32'h0001_a5a5, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_LCKR,   32'h0,         16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_LCKR,   32'h0000_a5a5, 16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_LCKR,   32'h0001_a5a5, 16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_LCKR,   32'hffff_a5a5, 16'h0));
        send_access(make_access(gpl_pkg::REQ_WRITE, gpl_pkg::SEL_LCKR,   32'hfffe_5a5a, 16'h0));
        send_access(make_access(gpl_pkg::REQ_READ,  gpl_pkg::SEL_LCKR,   32'h0,         16'h0));

        unlock_at = RANDOM_ACCESSES / 3 + $urandom_range(RANDOM_ACCESSES / 3);
        key_pos   = 0;
        seq_bits  = '0;
        for (int i = 0; i < RANDOM_ACCESSES; i++)
        begin
            if (i == RANDOM_ACCESSES / 3)
            begin
                src_idle_pct  = 71;
                sink_idle_pct = 21;
            end
            if (i == 2 * RANDOM_ACCESSES / 3)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                start_hold    = 1'b1;
            end
            a = make_access(1'($urandom_range(1)), 3'($urandom_range(7)), $urandom,
                            16'($urandom));
            if ($urandom_range(99) < 20)
            begin
                a.req_type   = gpl_pkg::REQ_WRITE;
                a.reg_select = gpl_pkg::SEL_LCKR;
                case (key_pos)
                    0:
                    begin
                        seq_bits                        = 16'($urandom);
                        a.write_data[15:0]              = seq_bits;
                        a.write_data[gpl_pkg::KEY_POS]  = 1'b1;
                        key_pos                         = 1;
                    end
                    1:
                    begin
                        a.write_data[15:0]             = seq_bits;
                        a.write_data[gpl_pkg::KEY_POS] = 1'b0;
                        key_pos                        = 2;
                        if ($urandom_range(9) == 0)
                        begin
                            a.write_data[15:0] = 16'($urandom);
                            key_pos            = 0;
                        end
                    end
                    2:
                    begin
                        a.write_data[15:0]             = seq_bits;
                        a.write_data[gpl_pkg::KEY_POS] = 1'b1;
                        key_pos                        = 3;
                    end
                    default:
                    begin
                        if (i >= unlock_at)
                            a.req_type = gpl_pkg::REQ_READ;
                        key_pos = 0;
                    end
                endcase
            end
            else if (a.reg_select == gpl_pkg::SEL_LCKR)
            begin
                if (a.req_type == gpl_pkg::REQ_WRITE)
                    key_pos = 0;
                else if (key_pos == 3 && i < unlock_at)
                    a.reg_select = gpl_pkg::SEL_IDR;
            end
            send_access(a);
        end
        req_ch.valid <= 1'b0;

        while (sb.expected_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d responses over %0d reads and %0d writes, %0d mismatches",
                 sb.results_seen, sb.reads, sb.writes, sb.mismatches);
        $display("key sequence engaged the lock at access %0d; response side held for %0d cycles",
                 sb.lock_at, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
